FILE: src/cls_pkg.sv
package cls_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND    = 2'd0,
    MODE_REPLICATE = 2'd1,
    MODE_COMPACT   = 2'd2,
    MODE_READ      = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MISMATCH  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

endpackage

FILE: src/consensus_log_store_unit.sv
// Replicated log store: entry terms and command handles kept in two single-port-read
// RAMs as a ring after a snapshot point. Issue a command with start while busy is low;
// exactly one result follows, shown for one cycle with done, and it cannot be held off.
// The ring RAMs have a registered read, so a command that needs the ring is a read then
// a write-back: a local append (mode 0) needs no read and is decided in S_A; compact, read
// and replication items other than the one below are decided in S_EVAL_A, and a replication
// entry that lands inside the live log needs a second read in S_EVAL_B. A new command is
// accepted in the cycle done is high. The ring needs no clearing after reset.
module consensus_log_store_unit import cls_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] log_index,
  input  logic [31:0] entry_term,
  input  logic [31:0] prev_term,
  input  logic [9:0]  batch_offset,
  input  logic        has_entry,
  input  logic [31:0] command_handle,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] assigned_index,
  output logic [31:0] found_term,
  output logic [31:0] found_command,
  output logic [31:0] last_index,
  output logic [31:0] last_term
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_A,
    S_EVAL_A,
    S_EVAL_B
  } state_t;

  state_t state, state_next;

  // latched command
  mode_t        req_mode;
  logic [31:0]  req_index;
  logic [31:0]  req_term;
  logic [31:0]  req_prev_term;
  logic [9:0]   req_offset;
  logic         req_has;
  logic [31:0]  req_cmd;

  // log state
  logic [31:0]   snap_point, snap_point_next;
  logic [31:0]   snap_term, snap_term_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [AW-1:0] head_slot, head_slot_next;
  logic [31:0]   tail_term, tail_term_next;

  logic [1:0]  status_next;
  logic [31:0] assigned_next, found_term_next, found_cmd_next;
  logic        done_next;

  // ring RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   rd_term, rd_cmd;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [AW-1:0] rel);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, rel};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  cls_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_term_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req_term),
    .raddr (ram_raddr),
    .rdata (rd_term)
  );

  cls_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_cmd_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req_cmd),
    .raddr (ram_raddr),
    .rdata (rd_cmd)
  );

  // index arithmetic on the latched command and current state
  logic [32:0]   last_ext;
  logic          a_in_ring, a_is_snap;
  logic [31:0]   a_rel;
  logic [AW-1:0] a_slot;
  logic [31:0]   term_a;
  logic [32:0]   ni;
  logic          b_past_snap, b_pos_lt, b_pos_gt;
  logic [32:0]   b_pos;
  logic [AW-1:0] b_slot, append_slot, head_drop;
  logic [31:0]   drop;
  logic          count_full;

  always_comb begin
    last_ext    = {1'b0, snap_point} + 33'(entry_count);
    a_in_ring   = (req_index > snap_point) && ({1'b0, req_index} <= last_ext);
    a_is_snap   = (req_index == snap_point);
    a_rel       = req_index - snap_point - 32'd1;
    a_slot      = slot_of(head_slot, a_rel[AW-1:0]);
    term_a      = a_in_ring ? rd_term : (a_is_snap ? snap_term : 32'd0);
    ni          = {1'b0, req_index} + 33'd1 + 33'(req_offset);
    b_past_snap = ni > {1'b0, snap_point};
    b_pos       = ni - {1'b0, snap_point} - 33'd1;
    b_pos_lt    = b_pos < 33'(entry_count);
    b_pos_gt    = b_pos > 33'(entry_count);
    b_slot      = slot_of(head_slot, b_pos[AW-1:0]);
    append_slot = slot_of(head_slot, entry_count[AW-1:0]);
    drop        = req_index - snap_point;
    head_drop   = slot_of(head_slot, drop[AW-1:0]);
    count_full  = entry_count >= CW'(DEPTH);
  end

  always_comb begin
    state_next       = state;
    snap_point_next  = snap_point;
    snap_term_next   = snap_term;
    entry_count_next = entry_count;
    head_slot_next   = head_slot;
    tail_term_next   = tail_term;
    status_next      = ST_OK;
    assigned_next    = 32'd0;
    found_term_next  = 32'd0;
    found_cmd_next   = 32'd0;
    done_next        = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = append_slot;
    ram_raddr        = a_slot;

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_A;
        end
      end

      S_A: begin
        // read of the checked index is in flight; local append needs no read
        if (req_mode == MODE_APPEND) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (count_full || last_ext >= 33'h0_FFFF_FFFF) begin
            status_next = ST_FULL;
          end else begin
            ram_we           = 1'b1;
            entry_count_next = entry_count + CW'(1);
            tail_term_next   = req_term;
            assigned_next    = last_ext[31:0] + 32'd1;
          end
        end else begin
          state_next = S_EVAL_A;
        end
      end

      S_EVAL_A: begin
        ram_raddr  = b_slot;
        done_next  = 1'b1;
        state_next = S_IDLE;
        case (req_mode)
          MODE_REPLICATE: begin
            if (req_index != 32'd0 && term_a != req_prev_term) begin
              status_next = ST_MISMATCH;
            end else if (!req_has) begin
              status_next = ST_OK;
            end else if (ni[32]) begin
              status_next = ST_FULL;
            end else if (!b_past_snap) begin
              assigned_next = ni[31:0];
            end else if (b_pos_lt) begin
              // entry overlaps the live log: compare its term first
              done_next  = 1'b0;
              state_next = S_EVAL_B;
            end else if (b_pos_gt) begin
              status_next = ST_MISMATCH;
            end else if (count_full) begin
              status_next = ST_FULL;
            end else begin
              ram_we           = 1'b1;
              entry_count_next = entry_count + CW'(1);
              tail_term_next   = req_term;
              assigned_next    = ni[31:0];
            end
          end
          MODE_COMPACT: begin
            if (req_index > snap_point) begin
              if (a_in_ring && rd_term == req_term &&
                  drop < 32'(entry_count)) begin
                head_slot_next   = head_drop;
                entry_count_next = entry_count - drop[CW-1:0];
              end else begin
                entry_count_next = '0;
                tail_term_next   = req_term;
              end
              snap_point_next = req_index;
              snap_term_next  = req_term;
            end
          end
          MODE_READ: begin
            if (a_in_ring) begin
              found_term_next = rd_term;
              found_cmd_next  = rd_cmd;
            end else begin
              status_next     = ST_NOT_FOUND;
              found_term_next = a_is_snap ? snap_term : 32'd0;
            end
          end
          default: begin
            status_next = ST_OK;
          end
        endcase
      end

      S_EVAL_B: begin
        done_next     = 1'b1;
        state_next    = S_IDLE;
        assigned_next = ni[31:0];
        // conflicting term: truncate after this slot and overwrite it
        if (rd_term != req_term) begin
          ram_we           = 1'b1;
          ram_waddr        = b_slot;
          entry_count_next = b_pos[CW-1:0] + CW'(1);
          tail_term_next   = req_term;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      snap_point  <= '0;
      snap_term   <= '0;
      entry_count <= '0;
      head_slot   <= '0;
      tail_term   <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      snap_point  <= snap_point_next;
      snap_term   <= snap_term_next;
      entry_count <= entry_count_next;
      head_slot   <= head_slot_next;
      tail_term   <= tail_term_next;
      done        <= done_next;
    end
    if (state == S_IDLE && start) begin
      req_mode      <= mode_t'(mode);
      req_index     <= log_index;
      req_term      <= entry_term;
      req_prev_term <= prev_term;
      req_offset    <= batch_offset;
      req_has       <= has_entry;
      req_cmd       <= command_handle;
    end
    status         <= status_next;
    assigned_index <= assigned_next;
    found_term     <= found_term_next;
    found_command  <= found_cmd_next;
  end

  assign busy       = (state != S_IDLE);
  assign last_index = last_ext[31:0];
  assign last_term  = tail_term;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a command is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(DEPTH))
    else $error("entry count exceeds ring depth");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted command did not occupy the unit");

  a_fail_no_index: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> assigned_index == 32'd0)
    else $error("failed command reported an assigned index");

endmodule

FILE: src/cls_ram.sv
module cls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
